### sv/nwps_pkg.sv
package nwps_pkg;

   // Largest number of neighbors that one vertex accumulates.
   localparam int MAX_NEIGHBORS = 256;
   localparam int TALLY_W = $clog2(MAX_NEIGHBORS + 1);
   // Signed width of the weight denominator count*max - sum(t).
   localparam int DEN_W = TALLY_W + 33;
   // Dividend of the amplitude division: |numerator| with 16 fraction bits appended.
   localparam int DIV_W = 80;
   localparam int SQRT_STEPS = 32;
   localparam logic [15:0] COS_THRESHOLD_RESET = 16'd28378;

   typedef enum logic [1:0] {
      KIND_CENTER = 2'd0,
      KIND_KEEP   = 2'd1,
      KIND_DROP   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic             last;
      logic [2:0][31:0] pos;
      logic [2:0][15:0] norm;
   } item_type;

endpackage

### sv/nwps_front.sv
module nwps_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [31:0]        req_pos_x,
   input  logic [31:0]        req_pos_y,
   input  logic [31:0]        req_pos_z,
   input  logic [15:0]        req_norm_x,
   input  logic [15:0]        req_norm_y,
   input  logic [15:0]        req_norm_z,
   input  logic               req_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_cos_threshold,
   output logic               q_valid,
   output nwps_pkg::item_type q_item,
   input  logic               q_pop
);

   logic [15:0]        thr_ff, thr_in;
   logic [2:0][15:0]   cnorm_ff, cnorm_in;
   nwps_pkg::item_type fifo_ff [2];
   logic               wptr_ff, wptr_in;
   logic               rptr_ff, rptr_in;
   logic [1:0]         cnt_ff, cnt_in;

   logic               push;
   logic signed [31:0] pr0, pr1, pr2;
   logic signed [33:0] dot, limit;
   nwps_pkg::item_type item;

   // The normal test runs against a shadow of the current center normal.
   assign pr0   = $signed(req_norm_x) * $signed(cnorm_ff[0]);
   assign pr1   = $signed(req_norm_y) * $signed(cnorm_ff[1]);
   assign pr2   = $signed(req_norm_z) * $signed(cnorm_ff[2]);
   assign dot   = 34'(pr0) + 34'(pr1) + 34'(pr2);
   assign limit = 34'($signed(thr_ff)) <<< 15;

   always_comb begin
      item.last = req_last;
      item.pos  = {req_pos_z, req_pos_y, req_pos_x};
      item.norm = {req_norm_z, req_norm_y, req_norm_x};
      if (!req_opcode) begin
         item.kind = nwps_pkg::KIND_CENTER;
      end else if (dot >= limit) begin
         item.kind = nwps_pkg::KIND_KEEP;
      end else begin
         item.kind = nwps_pkg::KIND_DROP;
      end
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign csr_ready = 1'b1;
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = fifo_ff[rptr_ff];

   always_comb begin
      thr_in   = csr_valid ? csr_cos_threshold : thr_ff;
      cnorm_in = (push && !req_opcode) ? item.norm : cnorm_ff;
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = q_pop ? ~rptr_ff : rptr_ff;
      cnt_in   = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= nwps_pkg::COS_THRESHOLD_RESET;
         cnorm_ff <= '0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         thr_ff   <= thr_in;
         cnorm_ff <= cnorm_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= item;
      end
   end

endmodule

### sv/nwps_back.sv
module nwps_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  nwps_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_out_x,
   output logic [31:0]        rsp_out_y,
   output logic [31:0]        rsp_out_z,
   output logic [8:0]         rsp_kept_count,
   output logic               rsp_zero_weight
);

   localparam int TW = nwps_pkg::TALLY_W;
   localparam int DW = nwps_pkg::DEN_W;
   localparam int VW = nwps_pkg::DIV_W;

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_DIFF = 14'b00000000000010,
      ST_MAC  = 14'b00000000000100,
      ST_VSAT = 14'b00000000001000,
      ST_VSQ  = 14'b00000000010000,
      ST_SQRT = 14'b00000000100000,
      ST_ACC  = 14'b00000001000000,
      ST_NUM0 = 14'b00000010000000,
      ST_NUM1 = 14'b00000100000000,
      ST_NUM2 = 14'b00001000000000,
      ST_DIV  = 14'b00010000000000,
      ST_AMP  = 14'b00100000000000,
      ST_OFFS = 14'b01000000000000,
      ST_EMIT = 14'b10000000000000
   } state_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sh7FFFFFFF) begin
         r = 32'h7FFFFFFF;
      end else if (x < -64'sh80000000) begin
         r = 32'h80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   state_type        state_ff, state_in;
   logic [1:0]       ax_ff, ax_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic [2:0][31:0] p_ff, p_in;
   logic [2:0][31:0] cpos_ff, cpos_in;
   logic [2:0][15:0] cnorm_ff, cnorm_in;
   logic [TW-1:0]    tally_ff, tally_in;
   logic [47:0]      sumv_ff, sumv_in;
   logic [47:0]      sumt_ff, sumt_in;
   logic [63:0]      svt_ff, svt_in;
   logic [31:0]      max_ff, max_in;
   logic [31:0]      d_ff, d_in;
   logic [63:0]      dsq_ff, dsq_in;
   logic [49:0]      vacc_ff, vacc_in;
   logic [31:0]      v_ff, v_in;
   logic [63:0]      sq_ff, sq_in;
   logic [32:0]      rem_ff, rem_in;
   logic [31:0]      root_ff, root_in;
   logic [79:0]      acc_ff, acc_in;
   logic [DW-1:0]    den_ff, den_in;
   logic             neg_ff, neg_in;
   logic             zw_ff, zw_in;
   logic [VW-1:0]    dvd_ff, dvd_in;
   logic [DW:0]      drem_ff, drem_in;
   logic [41:0]      amp_ff, amp_in;
   logic [2:0][31:0] oc_ff, oc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0][31:0] rsp_pos_ff, rsp_pos_in;
   logic [8:0]       rsp_kept_ff, rsp_kept_in;
   logic             rsp_zw_ff, rsp_zw_in;

   logic signed [32:0] diff;
   logic [31:0]        dmag, vmag;
   logic [63:0]        dsqr, vsqr;
   logic signed [47:0] vprod;
   logic signed [49:0] vsh;
   logic [34:0]        r2, rtrial;
   logic signed [63:0] vtp;
   logic [55:0]        plo;
   logic signed [56:0] phi;
   logic [TW+31:0]     tmax;
   logic signed [63:0] numv;
   logic [DW:0]        dtrial;
   logic               dge;
   logic [40:0]        mag;
   logic signed [57:0] mvp;
   logic signed [42:0] mvs;
   logic signed [63:0] sumc;
   logic               to_end;

   assign diff   = $signed({p_ff[ax_ff][31], p_ff[ax_ff]})
                 - $signed({cpos_ff[ax_ff][31], cpos_ff[ax_ff]});
   assign dmag   = d_ff[31] ? (~d_ff + 32'd1) : d_ff;
   assign dsqr   = dmag * dmag;
   assign vprod  = $signed(d_ff) * $signed(cnorm_ff[ax_ff]);
   assign vsh    = $signed(vacc_ff) >>> 15;
   assign vmag   = v_ff[31] ? (~v_ff + 32'd1) : v_ff;
   assign vsqr   = vmag * vmag;
   assign r2     = {rem_ff, sq_ff[63:62]};
   assign rtrial = {1'b0, root_ff, 2'b01};
   assign vtp    = $signed(v_ff) * $signed({1'b0, root_ff});
   assign plo    = max_ff * sumv_ff[23:0];
   assign phi    = $signed({1'b0, max_ff}) * $signed(sumv_ff[47:24]);
   assign tmax   = tally_ff * max_ff;
   assign numv   = $signed(acc_ff[79:16]) - $signed(svt_ff);
   assign dtrial = {drem_ff[DW-1:0], dvd_ff[VW-1]};
   assign dge    = (dtrial >= {1'b0, den_ff});
   assign mag    = (dvd_ff > VW'(41'h10000000000)) ? 41'h10000000000 : dvd_ff[40:0];
   assign mvp    = $signed(amp_ff) * $signed(cnorm_ff[ax_ff]);
   assign mvs    = 43'(mvp >>> 15);
   assign sumc   = 64'($signed(cpos_ff[ax_ff])) + 64'(mvs);

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      p_in         = p_ff;
      cpos_in      = cpos_ff;
      cnorm_in     = cnorm_ff;
      tally_in     = tally_ff;
      sumv_in      = sumv_ff;
      sumt_in      = sumt_ff;
      svt_in       = svt_ff;
      max_in       = max_ff;
      d_in         = d_ff;
      dsq_in       = dsq_ff;
      vacc_in      = vacc_ff;
      v_in         = v_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      zw_in        = zw_ff;
      dvd_in       = dvd_ff;
      drem_in      = drem_ff;
      amp_in       = amp_ff;
      oc_in        = oc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_zw_in    = rsp_zw_ff;
      q_pop        = 1'b0;
      to_end       = q_item.last;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               last_in = q_item.last;
               p_in    = q_item.pos;
               state_in = to_end ? ST_NUM0 : ST_IDLE;
               case (q_item.kind)
                  nwps_pkg::KIND_CENTER: begin
                     cpos_in  = q_item.pos;
                     cnorm_in = q_item.norm;
                     tally_in = '0;
                     sumv_in  = '0;
                     sumt_in  = '0;
                     svt_in   = '0;
                     max_in   = '0;
                  end
                  nwps_pkg::KIND_KEEP: begin
                     if (tally_ff < TW'(nwps_pkg::MAX_NEIGHBORS)) begin
                        ax_in    = 2'd0;
                        dsq_in   = '0;
                        vacc_in  = '0;
                        state_in = ST_DIFF;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIFF: begin
            d_in     = sat32(64'(diff));
            state_in = ST_MAC;
         end
         ST_MAC: begin
            dsq_in  = dsq_ff + dsqr;
            vacc_in = vacc_ff + 50'(vprod);
            ax_in   = ax_ff + 2'd1;
            state_in = (ax_ff == 2'd2) ? ST_VSAT : ST_DIFF;
         end
         ST_VSAT: begin
            v_in     = sat32(64'(vsh));
            state_in = ST_VSQ;
         end
         ST_VSQ: begin
            sq_in    = (dsq_ff > vsqr) ? (dsq_ff - vsqr) : 64'd0;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (r2 >= rtrial) begin
               rem_in  = 33'(r2 - rtrial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = r2[32:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            sq_in  = {sq_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(nwps_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            tally_in = tally_ff + TW'(1);
            sumv_in  = sumv_ff + 48'($signed(v_ff));
            sumt_in  = sumt_ff + {16'd0, root_ff};
            svt_in   = svt_ff + 64'(vtp >>> 16);
            max_in   = (root_ff > max_ff) ? root_ff : max_ff;
            state_in = last_ff ? ST_NUM0 : ST_IDLE;
         end
         ST_NUM0: begin
            acc_in   = {24'd0, plo};
            state_in = ST_NUM1;
         end
         ST_NUM1: begin
            acc_in   = acc_ff + ({{23{phi[56]}}, phi} << 24);
            den_in   = {1'b0, tmax} - DW'(sumt_ff);
            state_in = ST_NUM2;
         end
         ST_NUM2: begin
            neg_in  = numv[63];
            dvd_in  = {(numv[63] ? (~numv + 64'sd1) : numv), 16'd0};
            drem_in = '0;
            cnt_in  = '0;
            if (den_ff[DW-1] || den_ff == '0) begin
               den_in = DW'(65536);
               zw_in  = 1'b1;
            end else begin
               zw_in  = 1'b0;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            drem_in = dge ? (dtrial - {1'b0, den_ff}) : dtrial;
            dvd_in  = {dvd_ff[VW-2:0], dge};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == 7'(VW - 1)) begin
               state_in = ST_AMP;
            end
         end
         ST_AMP: begin
            amp_in   = neg_ff ? (~{1'b0, mag} + 42'd1) : {1'b0, mag};
            ax_in    = 2'd0;
            state_in = ST_OFFS;
         end
         ST_OFFS: begin
            oc_in[ax_ff] = sat32(sumc);
            ax_in        = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = oc_ff;
               rsp_kept_in  = 9'(tally_ff);
               rsp_zw_in    = zw_ff;
               tally_in     = '0;
               sumv_in      = '0;
               sumt_in      = '0;
               svt_in       = '0;
               max_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cpos_ff      <= '0;
         cnorm_ff     <= '0;
         tally_ff     <= '0;
         sumv_ff      <= '0;
         sumt_ff      <= '0;
         svt_ff       <= '0;
         max_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cpos_ff      <= cpos_in;
         cnorm_ff     <= cnorm_in;
         tally_ff     <= tally_in;
         sumv_ff      <= sumv_in;
         sumt_ff      <= sumt_in;
         svt_ff       <= svt_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      p_ff        <= p_in;
      d_ff        <= d_in;
      dsq_ff      <= dsq_in;
      vacc_ff     <= vacc_in;
      v_ff        <= v_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      acc_ff      <= acc_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      zw_ff       <= zw_in;
      dvd_ff      <= dvd_in;
      drem_ff     <= drem_in;
      amp_ff      <= amp_in;
      oc_ff       <= oc_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_kept_ff <= rsp_kept_in;
      rsp_zw_ff   <= rsp_zw_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_pos_ff[0];
   assign rsp_out_y       = rsp_pos_ff[1];
   assign rsp_out_z       = rsp_pos_ff[2];
   assign rsp_kept_count  = rsp_kept_ff;
   assign rsp_zero_weight = rsp_zw_ff;

endmodule

### sv/normal_weighted_point_smoother.sv
// Normal-weighted point smoother. Send one center transaction (opcode 0)
// followed by its neighbor transactions (opcode 1); the transaction with
// last set closes the vertex and yields one result: the center moved along
// its normal by the weighted amplitude, saturated Q16.16, with the number of
// kept neighbors and a flag that the weight sum was zero. Neighbors whose
// normal dot product with the center normal falls below csr_cos_threshold
// (Q1.15) are dropped. In the back end a center or dropped neighbor is
// handled in the idle state, a kept neighbor runs through the 32-step
// bit-serial square root, and closing a vertex runs through the 80-step
// bit-serial amplitude divider. A two-entry queue sits between the
// classifying front end and the back end, and the result sits in an
// output register, so the input keeps flowing while a result waits.
module normal_weighted_point_smoother (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [15:0] req_norm_x,
   input  logic [15:0] req_norm_y,
   input  logic [15:0] req_norm_z,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [8:0]  rsp_kept_count,
   output logic        rsp_zero_weight,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_cos_threshold
);

   // Classified transactions handed from the front end to the back end.
   logic               q_valid;
   logic               q_pop;
   nwps_pkg::item_type q_item;

   // The front end owns the threshold and a copy of the center normal so
   // that each neighbor is tagged kept or dropped as it arrives.
   nwps_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_norm_x        (req_norm_x),
      .req_norm_y        (req_norm_y),
      .req_norm_z        (req_norm_z),
      .req_last          (req_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_cos_threshold (csr_cos_threshold),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // The back end measures kept neighbors, keeps the running sums and
   // computes the amplitude and the smoothed position.
   nwps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_kept_count  (rsp_kept_count),
      .rsp_zero_weight (rsp_zero_weight)
   );

endmodule

### sv/nwps_checker.sv
module nwps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_x,
   input logic [8:0]  rsp_kept_count,
   input logic        rsp_zero_weight
);

   // Results never appear straight out of reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("stalled result changed");

   // With no kept neighbor the weight sum is necessarily zero.
   a_empty_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kept_count == 9'd0 |-> rsp_zero_weight)
      else $error("empty vertex without zero weight flag");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kept_count <= 9'(nwps_pkg::MAX_NEIGHBORS))
      else $error("kept count beyond the neighbor limit");

endmodule

bind normal_weighted_point_smoother nwps_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_x       (rsp_out_x),
   .rsp_kept_count  (rsp_kept_count),
   .rsp_zero_weight (rsp_zero_weight)
);

### tb/sv/tb_normal_weighted_point_smoother.sv
`timescale 1ns / 1ps

module tb_normal_weighted_point_smoother;

   // Opcode values of an input transaction.
   localparam bit OP_CENTER   = 1'b0;
   localparam bit OP_NEIGHBOR = 1'b1;
   // Idle cycles that follow a phase: a kept neighbor plus closing a vertex,
   // with the two-entry queue in front, fits well inside this.
   localparam int SETTLE_CYCLES = 400;

   typedef struct packed {
      logic             op;
      logic             last;
      logic [2:0][31:0] pos;
      logic [2:0][15:0] norm;
   } point_item_type;

   typedef struct packed {
      logic [2:0][31:0] coord;
      logic [8:0]       kept;
      logic             zero_wt;
   } smoothed_point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic [15:0] req_norm_x = '0;
   logic [15:0] req_norm_y = '0;
   logic [15:0] req_norm_z = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [31:0] rsp_out_z;
   logic [8:0]  rsp_kept_count;
   logic        rsp_zero_weight;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_cos_threshold = '0;

   normal_weighted_point_smoother dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_norm_x(req_norm_x),
      .req_norm_y(req_norm_y),
      .req_norm_z(req_norm_z),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_kept_count(rsp_kept_count),
      .rsp_zero_weight(rsp_zero_weight),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_cos_threshold(csr_cos_threshold)
   );

   always #1 clock = ~clock;

   // Pending input transactions and the smoothed points we expect back.
   point_item_type     pending_points[$];
   smoothed_point_type expected_points[$];
   point_item_type     driven_point;

   // Idle rates in percent, set per phase by the stimulus block.
   int send_idle = 0;
   int recv_idle = 0;

   int errors = 0;
   int points_sent = 0;
   int vertices_closed = 0;
   int zero_weight_seen = 0;
   int kept_total = 0;

   // Shadow of the block's state: the current center and the running sums
   // of the vertex that is open.
   longint          threshold;
   longint          center_pos[3];
   longint          center_nrm[3];
   int              kept_tally;
   longint          sum_v;
   longint unsigned sum_t;
   longint          sum_vt;
   longint unsigned max_t;

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Floor of the square root, one result bit per step.
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= root + b) begin
            x -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic void clear_vertex_sums();
      kept_tally = 0;
      sum_v = 0;
      sum_t = 0;
      sum_vt = 0;
      max_t = 0;
   endfunction

   // Append one transaction to the stimulus queue.
   function automatic void enqueue_point(point_item_type it);
      pending_points.insert(pending_points.size(), it);
   endfunction

   // Fold one neighbor into the running sums, unless its normal points too
   // far away from the center normal or the tally is already full.
   function automatic void accumulate_neighbor(point_item_type it);
      longint          dot;
      longint          vacc;
      longint          d;
      longint          v;
      longint unsigned dsq;
      longint unsigned dm;
      longint unsigned vm;
      longint unsigned sq;
      longint unsigned t;
      dot = 0;
      vacc = 0;
      dsq = 0;
      for (int i = 0; i < 3; i++)
         dot += longint'($signed(it.norm[i])) * center_nrm[i];
      if (dot < threshold * 32768) return;
      if (kept_tally >= nwps_pkg::MAX_NEIGHBORS) return;
      for (int i = 0; i < 3; i++) begin
         d = sat32(longint'($signed(it.pos[i])) - center_pos[i]);
         vacc += d * center_nrm[i];
         dm = d < 0 ? longint'(-d) : d;
         dsq += dm * dm;
      end
      v = sat32(vacc >>> 15);
      vm = v < 0 ? longint'(-v) : v;
      sq = dsq > vm * vm ? dsq - vm * vm : 0;
      t = floor_sqrt(sq);
      kept_tally++;
      sum_v += v;
      sum_t += t;
      sum_vt += (v * longint'(t)) >>> 16;
      if (t > max_t) max_t = t;
   endfunction

   // Close the vertex: move the center along its normal by the weighted
   // amplitude and clear the sums (the center itself stays).
   function automatic smoothed_point_type close_vertex();
      smoothed_point_type res;
      longint          num;
      longint          den;
      longint          mh;
      longint          ml;
      longint          amp;
      longint unsigned a;
      longint unsigned q;
      longint unsigned r;
      longint unsigned mag;
      mh = longint'(max_t >> 16);
      ml = longint'(max_t & 64'hFFFF);
      num = mh * sum_v + ((ml * sum_v) >>> 16) - sum_vt;
      den = longint'(kept_tally) * longint'(max_t) - longint'(sum_t);
      res.zero_wt = 1'b0;
      if (den <= 0) begin
         den = 65536;
         res.zero_wt = 1'b1;
      end
      a = num < 0 ? 64'd0 - longint'(num) : num;
      q = a / longint'(den);
      r = a % longint'(den);
      if (q > (64'd1 << 24)) q = 64'd1 << 24;
      mag = (q << 16) + ((r << 16) / longint'(den));
      if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      amp = num < 0 ? -longint'(mag) : longint'(mag);
      for (int i = 0; i < 3; i++)
         res.coord[i] = 32'(sat32(center_pos[i] + ((amp * center_nrm[i]) >>> 15)));
      res.kept = kept_tally[8:0];
      clear_vertex_sums();
      return res;
   endfunction

   function automatic void predict_point(point_item_type it);
      if (it.op == OP_CENTER) begin
         for (int i = 0; i < 3; i++) begin
            center_pos[i] = longint'($signed(it.pos[i]));
            center_nrm[i] = longint'($signed(it.norm[i]));
         end
         clear_vertex_sums();
      end else begin
         accumulate_neighbor(it);
      end
      if (it.last) expected_points.insert(expected_points.size(), close_vertex());
   endfunction

   // Driver: a transaction accepted at this edge goes to the predictor, then
   // the next pending point is presented unless the sender idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_point(driven_point);
            points_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= send_idle) begin
               driven_point = pending_points.pop_front();
               req_valid  <= 1'b1;
               req_opcode <= driven_point.op;
               req_last   <= driven_point.last;
               req_pos_x  <= driven_point.pos[0];
               req_pos_y  <= driven_point.pos[1];
               req_pos_z  <= driven_point.pos[2];
               req_norm_x <= driven_point.norm[0];
               req_norm_y <= driven_point.norm[1];
               req_norm_z <= driven_point.norm[2];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, and check every accepted result against the
   // oldest expectation.
   always @(posedge clock) begin
      smoothed_point_type want;
      smoothed_point_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.coord[0] = rsp_out_x;
         got.coord[1] = rsp_out_y;
         got.coord[2] = rsp_out_z;
         got.kept = rsp_kept_count;
         got.zero_wt = rsp_zero_weight;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h kept=%0d zw=%b", $realtime,
                     got.coord[0], got.coord[1], got.coord[2], got.kept, got.zero_wt);
            errors++;
         end else begin
            want = expected_points.pop_front();
            vertices_closed++;
            if (got.zero_wt) zero_weight_seen++;
            kept_total += got.kept;
            for (int i = 0; i < 3; i++)
               if (got.coord[i] !== want.coord[i]) begin
                  $display("%0t: coordinate %0d expected %h actual %h", $realtime, i,
                           want.coord[i], got.coord[i]);
                  errors++;
               end
            if (got.kept !== want.kept) begin
               $display("%0t: kept_count expected %0d actual %0d", $realtime,
                        want.kept, got.kept);
               errors++;
            end
            if (got.zero_wt !== want.zero_wt) begin
               $display("%0t: zero_weight expected %b actual %b", $realtime,
                        want.zero_wt, got.zero_wt);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic point_item_type make_point(bit op, bit last, logic [2:0][31:0] p,
                                                 logic [2:0][15:0] n);
      point_item_type it;
      it.op = op;
      it.last = last;
      it.pos = p;
      it.norm = n;
      return it;
   endfunction

   // A plausible unit normal: one dominant axis, the others small. Now and
   // then an arbitrary bit pattern instead.
   function automatic logic [2:0][15:0] random_normal();
      logic [2:0][15:0] n;
      int axis;
      if ($urandom_range(9) == 0) return 48'({$urandom, $urandom});
      axis = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
         if (i == axis) n[i] = 16'($urandom_range(32767, 26000));
         else n[i] = 16'($urandom_range(12000));
         if ($urandom_range(1)) n[i] = -n[i];
      end
      return n;
   endfunction

   function automatic logic [2:0][15:0] jitter_normal(logic [2:0][15:0] n);
      logic [2:0][15:0] j;
      int c;
      for (int i = 0; i < 3; i++) begin
         c = int'($signed(n[i])) + $urandom_range(1200) - 600;
         if (c > 32767) c = 32767;
         if (c < -32768) c = -32768;
         j[i] = 16'(c);
      end
      return j;
   endfunction

   // Queue one vertex: a center, then its neighbors near it. A few neighbors
   // are far off or face away; a few vertices are broken (no center, or no
   // closing mark, so the next vertex simply restarts the sums).
   task automatic queue_vertex(int neighbors);
      logic [2:0][31:0] c;
      logic [2:0][31:0] p;
      logic [2:0][15:0] cn;
      int span;
      bit skip_center;
      bit open_end;
      for (int i = 0; i < 3; i++)
         c[i] = ($urandom_range(3) == 0) ? $urandom : 32'($signed(16'($urandom)) * 256);
      cn = random_normal();
      skip_center = ($urandom_range(19) == 0) && neighbors > 0;
      open_end = ($urandom_range(19) == 0);
      if (!skip_center)
         enqueue_point(make_point(OP_CENTER, neighbors == 0 && !open_end, c, cn));
      for (int k = 0; k < neighbors; k++) begin
         span = $urandom_range(26, 6);
         for (int i = 0; i < 3; i++)
            p[i] = ($urandom_range(15) == 0) ? $urandom
                   : c[i] + 32'($signed(32'($urandom)) >>> (32 - span));
         enqueue_point(make_point(OP_NEIGHBOR,
            k == neighbors - 1 && !open_end, p,
            ($urandom_range(7) == 0) ? random_normal() : jitter_normal(cn)));
      end
   endtask

   // Write the threshold once the block is idle.
   task automatic write_threshold(logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_cos_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      threshold = longint'($signed(value));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_points.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [2:0][15:0] nx;
      logic [2:0][15:0] nmin;
      int quota;
      threshold = longint'($signed(nwps_pkg::COS_THRESHOLD_RESET));
      for (int i = 0; i < 3; i++) begin
         center_pos[i] = 0;
         center_nrm[i] = 0;
      end
      clear_vertex_sums();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed points at the reset threshold.
      nx = {16'sd0, 16'sd0, 16'sd32767};
      nmin = {16'h8000, 16'h8000, 16'h8000};
      // A neighbor ahead of any center meets the zero center normal and is dropped.
      enqueue_point(make_point(OP_NEIGHBOR, 1'b1, {32'd5, 32'd7, 32'd9}, nx));
      // A center alone closes with no neighbors and a forced unit weight.
      enqueue_point(make_point(OP_CENTER, 1'b1,
         {32'h7FFFFFFF, 32'h80000000, 32'h0}, nmin));
      enqueue_point(make_point(OP_CENTER, 1'b1,
         {32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF}));
      // Extreme offsets saturate and push the output to its limits.
      enqueue_point(make_point(OP_CENTER, 1'b0, {32'h0, 32'h0, 32'h7FFF0000}, nx));
      enqueue_point(make_point(OP_NEIGHBOR, 1'b0,
         {32'h80000000, 32'h7FFFFFFF, 32'h80000000}, nx));
      enqueue_point(make_point(OP_NEIGHBOR, 1'b0,
         {32'h00010000, 32'h0, 32'h7FFFFFFF}, nx));
      // A neighbor that faces away is dropped.
      enqueue_point(make_point(OP_NEIGHBOR, 1'b0,
         {32'h00020000, 32'h0, 32'h0}, {16'h0, 16'h0, 16'h8001}));
      enqueue_point(make_point(OP_NEIGHBOR, 1'b1,
         {32'h00000100, 32'h00030000, 32'h7FFF8000}, nx));
      // After a result the center stays: these neighbors use it again.
      enqueue_point(make_point(OP_NEIGHBOR, 1'b0,
         {32'h00040000, 32'h0, 32'h7FFE0000}, nx));
      enqueue_point(make_point(OP_NEIGHBOR, 1'b1,
         {32'hFFFC0000, 32'h00010000, 32'h7FFF4000}, nx));
      // A small regular vertex with a tilted normal.
      enqueue_point(make_point(OP_CENTER, 1'b0,
         {32'h00100000, 32'hFFF00000, 32'h00080000}, {16'd3000, 16'd2000, 16'd32500}));
      for (int k = 0; k < 6; k++)
         enqueue_point(make_point(OP_NEIGHBOR, k == 5,
            {32'h00100000 + 32'($urandom_range(65535 * 4)),
             32'hFFF00000 + 32'($urandom_range(65535 * 4)),
             32'h00080000 + 32'($urandom_range(65535))},
            {16'd2900, 16'd2100, 16'd32400}));
      wait_idle();

      // Random phases, each with its own threshold; phases 2 and 5 keep the idle pattern of the phase before.
      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: begin
               write_threshold(16'h8000);
               send_idle = 15;
               recv_idle = 87;
            end
            2: write_threshold(16'h7FFF);
            3: begin
               write_threshold(16'h0000);
               send_idle = 87;
               recv_idle = 15;
            end
            4: begin
               write_threshold(16'($urandom));
               send_idle = 0;
               recv_idle = 0;
            end
            default: write_threshold(nwps_pkg::COS_THRESHOLD_RESET);
         endcase
         if (phase == 3) begin
            // One vertex long enough to fill the tally; the extra
            // neighbors are ignored and the last one still closes it.
            enqueue_point(make_point(OP_CENTER, 1'b0, '0, nx));
            for (int k = 0; k < nwps_pkg::MAX_NEIGHBORS + 4; k++)
               enqueue_point(make_point(OP_NEIGHBOR, k == nwps_pkg::MAX_NEIGHBORS + 3,
                  {32'($urandom_range(65535 * 8)), 32'($urandom_range(65535 * 8)),
                   32'($signed(16'($urandom)))}, nx));
         end
         quota = 195;
         while (quota > 0) begin
            int n;
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
            queue_vertex(n);
            quota -= n + 1;
         end
         wait_idle();
      end

      $display("Covered %0d transactions, %0d smoothed vertices, %0d kept neighbors,",
               points_sent, vertices_closed, kept_total);
      $display("%0d zero-weight vertices, over five threshold settings.", zero_weight_seen);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
